### src/sorted_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// condition in this cycle implies a check in the next cycle
`define SPQ_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> ##1 (expr)) else $error(msg);

// condition implies a check in the same cycle
`define SPQ_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (expr)) else $error(msg);

`endif

### src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [15:0] prio;
        logic [7:0]         value;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

### src/spq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_in_if
// request channel: operation code and item to push
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [7:0]         item_value;
    logic signed [15:0] item_priority;

    modport source (output valid, output op, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input op, input item_value, input item_priority,
                    output ready);
endinterface

### src/spq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_out_if
// response channel: status, popped entry and queue flags
// ----------------------------------------------------------------------------
interface spq_out_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [7:0]         out_value;
    logic signed [15:0] out_priority;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output ok, output out_value, output out_priority,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input out_value, input out_priority,
                    input is_empty, input is_full, output ready);
endinterface

### src/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer: takes a request, runs it once the response register is free
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// sorted entry row with parallel compare and shift, response register
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_item_value,
    input  logic signed [15:0] i_item_priority,
    output logic               o_ok,
    output logic [7:0]         o_out_value,
    output logic signed [15:0] o_out_priority,
    output logic               o_is_empty,
    output logic               o_is_full
);

    logic [1:0]         r_op;
    t_entry             r_new;
    t_entry             r_entry [DEPTH];
    t_entry             n_entry [DEPTH];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [DEPTH-1:0]   w_le;

    logic               r_ok, n_ok;
    logic [7:0]         r_out_value, n_out_value;
    logic signed [15:0] r_out_priority, n_out_priority;
    logic               r_is_empty, r_is_full;

    // entry i is stored and the new one does not outrank it
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_le[i] = (CNT_W'(i) < r_count) && (r_entry[i].prio <= r_new.prio);
        end
    end

    always_comb begin
        n_entry        = r_entry;
        n_count        = r_count;
        n_ok           = 1'b0;
        n_out_value    = '0;
        n_out_priority = '0;
        case (r_op)
            OP_PUSH: begin
                if (r_count != CNT_W'(DEPTH)) begin
                    if (!w_le[0]) begin
                        n_entry[0] = r_new;
                    end
                    for (int i = 1; i < DEPTH; i++) begin
                        if (!w_le[i]) begin
                            n_entry[i] = w_le[i-1] ? r_new : r_entry[i-1];
                        end
                    end
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_POP: begin
                if (r_count != '0) begin
                    n_out_value    = r_entry[0].value;
                    n_out_priority = r_entry[0].prio;
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_entry[i] = r_entry[i+1];
                    end
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_new.value <= i_item_value;
            r_new.prio  <= i_item_priority;
        end
        if (i_cmd.execute) begin
            r_entry        <= n_entry;
            r_ok           <= n_ok;
            r_out_value    <= n_out_value;
            r_out_priority <= n_out_priority;
            r_is_empty     <= (n_count == '0);
            r_is_full      <= (n_count == CNT_W'(DEPTH));
        end
    end

    assign o_ok           = r_ok;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_priority;
    assign o_is_empty     = r_is_empty;
    assign o_is_full      = r_is_full;

endmodule

### src/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// bounded priority queue kept in ascending order of priority number
// ----------------------------------------------------------------------------
// usage:
//   i_cmd carries one request beat: op (push, pop, clear), item_value and
//   item_priority; o_rsp returns one response beat per request with ok, the
//   popped entry (zero unless a pop succeeds) and the empty and full flags
//   push places the item behind all entries of equal or lower priority
//   number, so equal priorities leave in arrival order
//   a request is captured, then executed once the response register is free;
//   a new request is taken only after the previous one has executed, set by
//   the capture and execute steps of the sequencer; the compare and shift
//   over the entry row is one parallel step
//   a stalled response is held in the output register; the next request is
//   still taken and waits in the execute step until that beat leaves
//   reset empties the queue and drops any pending response; entry contents
//   are not cleared, the fill count masks them
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_in_if.sink    i_cmd,
    spq_out_if.source o_rsp
);

    // command bundle from sequencer to datapath
    t_cmd w_cmd;

    // sequencer: request handshake and response valid
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    // entry row, fill count and response payload
    spq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_op            (i_cmd.op),
        .i_item_value    (i_cmd.item_value),
        .i_item_priority (i_cmd.item_priority),
        .o_ok            (o_rsp.ok),
        .o_out_value     (o_rsp.out_value),
        .o_out_priority  (o_rsp.out_priority),
        .o_is_empty      (o_rsp.is_empty),
        .o_is_full       (o_rsp.is_full)
    );

endmodule

### src/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of the sorted priority queue
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_assert.svh"

module spq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_ok,
    input logic [7:0]  i_out_value,
    input logic [15:0] i_out_priority,
    input logic        i_is_empty,
    input logic        i_is_full
);

    // a stalled response beat keeps its payload
    `SPQ_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable({i_ok, i_out_value, i_out_priority, i_is_empty, i_is_full}),
        "stalled response changed")

    // a request is executed before another is taken
    `SPQ_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready,
        "request taken while one is in flight")

    // queue cannot be empty and full at once
    `SPQ_ASSERT_SAME(a_flags_excl, i_out_valid, !(i_is_empty && i_is_full),
        "empty and full both set")

    // a failed operation returns no entry
    `SPQ_ASSERT_SAME(a_fail_zero, i_out_valid && !i_ok,
        (i_out_value == 8'd0) && (i_out_priority == 16'd0),
        "failed operation returned an entry")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_ok           (o_rsp.ok),
    .i_out_value    (o_rsp.out_value),
    .i_out_priority (o_rsp.out_priority),
    .i_is_empty     (o_rsp.is_empty),
    .i_is_full      (o_rsp.is_full)
);
